// ===== rtl/protobuf_field_extractor_unit_defines.svh =====
// Assertion macros shared by the protobuf field extractor RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef PROTOBUF_FIELD_EXTRACTOR_UNIT_DEFINES_SVH
`define PROTOBUF_FIELD_EXTRACTOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define PFE_ASSERT_NOW(label, clk_sig, rst_sig, ante, cons, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define PFE_ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/pfe_pkg.sv =====
// Package for the protobuf field extractor: types, status codes and constants.
// No dependencies; used by pfe_parser and protobuf_field_extractor_unit.
`timescale 1ns / 1ps

package pfe_pkg;

  // Largest payload or skip length that the counters track.
  localparam int unsigned MAX_MESSAGE_BYTES = 65536;
  localparam int unsigned SKIP_W = $clog2(MAX_MESSAGE_BYTES + 1);

  // Field widths.
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned VALUE_W = 64;
  localparam int unsigned FIELD_W = 29;
  localparam int unsigned CNT_W = 4;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = FIELD_W;

  // Index of the last varint byte (ten bytes at most).
  localparam logic [CNT_W-1:0] VARINT_LAST_IDX = 4'd9;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_FIELD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_MODE = 1'b1;

  // Search modes.
  localparam logic MODE_VARINT = 1'b0;
  localparam logic MODE_PAYLOAD = 1'b1;

  // Wire types that the parser understands.
  localparam logic [2:0] WT_VARINT = 3'd0;
  localparam logic [2:0] WT_FIXED64 = 3'd1;
  localparam logic [2:0] WT_LEN = 3'd2;
  localparam logic [2:0] WT_FIXED32 = 3'd5;

  // Skip lengths of the fixed-size wire types.
  localparam logic [SKIP_W-1:0] FIXED64_BYTES = SKIP_W'(8);
  localparam logic [SKIP_W-1:0] FIXED32_BYTES = SKIP_W'(4);

  typedef enum logic [2:0] {
    PH_TAG     = 3'd0,
    PH_VALUE   = 3'd1,
    PH_LENGTH  = 3'd2,
    PH_SKIP    = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_DONE    = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    ST_VARINT    = 3'd0,
    ST_BYTE      = 3'd1,
    ST_LAST      = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_NOTFOUND  = 3'd4,
    ST_MALFORMED = 3'd5,
    ST_TRUNC     = 3'd6
  } status_t;

  // Result of one input byte, passed from the parser to the output stage.
  typedef struct packed {
    logic               have;
    status_t            status;
    logic [VALUE_W-1:0] value;
  } pfe_result_t;

endpackage

// ===== rtl/pfe_parser.sv =====
// Byte-wise protobuf wire-format parser: state registers and the per-byte logic.
// Depends on pfe_pkg. Produces at most one result per accepted byte, combinationally.
`timescale 1ns / 1ps

module pfe_parser (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           accept,
  input  logic [pfe_pkg::BYTE_W-1:0]     data_byte,
  input  logic                           end_of_message,
  input  logic [pfe_pkg::FIELD_W-1:0]    target_field,
  input  logic                           search_mode,
  output pfe_pkg::pfe_result_t           result
);

  pfe_pkg::phase_t                  phase, phase_next;
  logic [pfe_pkg::VALUE_W-1:0]      acc, acc_next;
  logic [pfe_pkg::CNT_W-1:0]        count, count_next;
  logic                             field_matches, field_matches_next;
  logic [pfe_pkg::SKIP_W-1:0]       bytes_to_skip, bytes_to_skip_next;

  // Shared decode of the incoming byte.
  logic [6:0]                       shift_amt;
  logic [pfe_pkg::VALUE_W-1:0]      acc_upd;
  logic [pfe_pkg::CNT_W-1:0]        count_upd;
  logic                             vb_done, vb_over;
  logic [2:0]                       wt;
  logic                             tag_same;
  logic                             len_zero, len_big;
  logic [pfe_pkg::SKIP_W-1:0]       skip_dec, len_sat;
  logic                             skip_last;

  // Varint byte step, tag fields and length checks.
  always_comb begin
    shift_amt = 7'({3'd0, count} * 7'd7);
    acc_upd   = acc | ({{(pfe_pkg::VALUE_W-7){1'b0}}, data_byte[6:0]} << shift_amt);
    count_upd = count + 1'b1;
    vb_over   = (count > pfe_pkg::VARINT_LAST_IDX) ||
                (data_byte[7] && (count == pfe_pkg::VARINT_LAST_IDX));
    vb_done   = !data_byte[7];
    wt        = acc_upd[2:0];
    tag_same  = (acc_upd[63:32] == 32'd0) && (acc_upd[31:3] == target_field);
    len_zero  = (acc_upd == '0);
    len_big   = (acc_upd > pfe_pkg::VALUE_W'(pfe_pkg::MAX_MESSAGE_BYTES));
    len_sat   = len_big ? pfe_pkg::SKIP_W'(pfe_pkg::MAX_MESSAGE_BYTES)
                        : acc_upd[pfe_pkg::SKIP_W-1:0];
    skip_dec  = (bytes_to_skip != '0) ? bytes_to_skip - 1'b1 : bytes_to_skip;
    skip_last = (skip_dec == '0);
  end

  // Next state before the end-of-message clear.
  always_comb begin
    phase_next         = phase;
    acc_next           = acc;
    count_next         = count;
    field_matches_next = field_matches;
    bytes_to_skip_next = bytes_to_skip;
    unique case (phase)
      pfe_pkg::PH_TAG: begin
        acc_next   = acc_upd;
        count_next = count_upd;
        if (vb_over) begin
          phase_next = pfe_pkg::PH_DONE;
        end else if (vb_done) begin
          case (wt)
            pfe_pkg::WT_VARINT: begin
              field_matches_next = (search_mode == pfe_pkg::MODE_VARINT) && tag_same;
              phase_next = pfe_pkg::PH_VALUE;
              acc_next   = '0;
              count_next = '0;
            end
            pfe_pkg::WT_LEN: begin
              field_matches_next = (search_mode == pfe_pkg::MODE_PAYLOAD) && tag_same;
              phase_next = pfe_pkg::PH_LENGTH;
              acc_next   = '0;
              count_next = '0;
            end
            pfe_pkg::WT_FIXED64: begin
              bytes_to_skip_next = pfe_pkg::FIXED64_BYTES;
              phase_next = pfe_pkg::PH_SKIP;
            end
            pfe_pkg::WT_FIXED32: begin
              bytes_to_skip_next = pfe_pkg::FIXED32_BYTES;
              phase_next = pfe_pkg::PH_SKIP;
            end
            default: phase_next = pfe_pkg::PH_DONE;
          endcase
        end
      end
      pfe_pkg::PH_VALUE: begin
        acc_next   = acc_upd;
        count_next = count_upd;
        if (vb_over) begin
          phase_next = pfe_pkg::PH_DONE;
        end else if (vb_done) begin
          if (field_matches) begin
            phase_next = pfe_pkg::PH_DONE;
          end else begin
            phase_next = pfe_pkg::PH_TAG;
            acc_next   = '0;
            count_next = '0;
          end
        end
      end
      pfe_pkg::PH_LENGTH: begin
        acc_next   = acc_upd;
        count_next = count_upd;
        if (vb_over) begin
          phase_next = pfe_pkg::PH_DONE;
        end else if (vb_done) begin
          if (field_matches) begin
            if (len_zero || len_big) begin
              phase_next = pfe_pkg::PH_DONE;
            end else begin
              bytes_to_skip_next = len_sat;
              phase_next = pfe_pkg::PH_PAYLOAD;
            end
          end else if (len_zero) begin
            phase_next = pfe_pkg::PH_TAG;
            acc_next   = '0;
            count_next = '0;
          end else begin
            bytes_to_skip_next = len_sat;
            phase_next = pfe_pkg::PH_SKIP;
          end
        end
      end
      pfe_pkg::PH_SKIP: begin
        bytes_to_skip_next = skip_dec;
        if (skip_last) begin
          phase_next = pfe_pkg::PH_TAG;
          acc_next   = '0;
          count_next = '0;
        end
      end
      pfe_pkg::PH_PAYLOAD: begin
        bytes_to_skip_next = skip_dec;
        if (skip_last) begin
          phase_next = pfe_pkg::PH_DONE;
        end
      end
      default: phase_next = pfe_pkg::PH_DONE;
    endcase
  end

  // Result of the current byte.
  always_comb begin
    result.have   = 1'b0;
    result.status = pfe_pkg::ST_NOTFOUND;
    result.value  = '0;
    unique case (phase)
      pfe_pkg::PH_TAG: begin
        if (vb_over) begin
          result.have   = 1'b1;
          result.status = pfe_pkg::ST_MALFORMED;
        end else if (vb_done) begin
          case (wt) inside
            pfe_pkg::WT_VARINT, pfe_pkg::WT_LEN, pfe_pkg::WT_FIXED64,
            pfe_pkg::WT_FIXED32: result.have = 1'b0;
            default: begin
              result.have   = 1'b1;
              result.status = pfe_pkg::ST_MALFORMED;
            end
          endcase
        end
      end
      pfe_pkg::PH_VALUE: begin
        if (vb_over) begin
          result.have   = 1'b1;
          result.status = pfe_pkg::ST_MALFORMED;
        end else if (vb_done && field_matches) begin
          result.have   = 1'b1;
          result.status = pfe_pkg::ST_VARINT;
          result.value  = acc_upd;
        end
      end
      pfe_pkg::PH_LENGTH: begin
        if (vb_over) begin
          result.have   = 1'b1;
          result.status = pfe_pkg::ST_MALFORMED;
        end else if (vb_done && field_matches && len_zero) begin
          result.have   = 1'b1;
          result.status = pfe_pkg::ST_EMPTY;
        end else if (vb_done && field_matches && len_big) begin
          result.have   = 1'b1;
          result.status = pfe_pkg::ST_TRUNC;
        end
      end
      pfe_pkg::PH_PAYLOAD: begin
        result.have  = 1'b1;
        result.value = {{(pfe_pkg::VALUE_W-pfe_pkg::BYTE_W){1'b0}}, data_byte};
        if (skip_last) begin
          result.status = pfe_pkg::ST_LAST;
        end else if (end_of_message) begin
          result.status = pfe_pkg::ST_TRUNC;
        end else begin
          result.status = pfe_pkg::ST_BYTE;
        end
      end
      default: result.have = 1'b0;
    endcase
    // A message that ends with nothing found and no verdict yet reports not found.
    if (end_of_message && !result.have && (phase_next != pfe_pkg::PH_DONE)) begin
      result.have   = 1'b1;
      result.status = pfe_pkg::ST_NOTFOUND;
      result.value  = '0;
    end
  end

  // State registers; the end of a message returns the parser to the tag phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= pfe_pkg::PH_TAG;
      acc           <= '0;
      count         <= '0;
      field_matches <= 1'b0;
      bytes_to_skip <= '0;
    end else if (accept) begin
      if (end_of_message) begin
        phase         <= pfe_pkg::PH_TAG;
        acc           <= '0;
        count         <= '0;
        field_matches <= 1'b0;
        bytes_to_skip <= '0;
      end else begin
        phase         <= phase_next;
        acc           <= acc_next;
        count         <= count_next;
        field_matches <= field_matches_next;
        bytes_to_skip <= bytes_to_skip_next;
      end
    end
  end

endmodule

// ===== rtl/protobuf_field_extractor_unit.sv =====
// Top level of the protobuf field extractor: configuration registers and output buffering.
// Depends on pfe_pkg, pfe_parser and protobuf_field_extractor_unit_defines.svh.
`timescale 1ns / 1ps
`include "protobuf_field_extractor_unit_defines.svh"

// The block takes one message byte per input transaction and can accept a new byte in
// every clock cycle unless the output buffer is full. Each byte is parsed in the cycle it
// is accepted; its result, if any, is registered in the result register, or in the skid
// register on a stall. A two-entry output buffer (result register plus skid register)
// lets input continue while one result waits; input tready drops only when both entries
// are full. tuser carries the status code, tdata the varint value or the payload byte in
// bits 7:0. Configuration writes take effect from the next byte and belong between messages.

module protobuf_field_extractor_unit (
  input  logic                              clk,
  input  logic                              rst,
  // Input stream.
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [pfe_pkg::BYTE_W-1:0]        s_axis_tdata,   // [7:0] data_byte
  input  logic                              s_axis_tlast,   // end_of_message
  // Result stream.
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [pfe_pkg::VALUE_W-1:0]       m_axis_tdata,   // [63:0] value
  output logic [2:0]                        m_axis_tuser,   // [2:0] status
  // Configuration write port.
  input  logic                              cfg_we,
  input  logic [pfe_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pfe_pkg::CFG_DATA_W-1:0]    cfg_data
);

  logic [pfe_pkg::FIELD_W-1:0] target_field;
  logic                        search_mode;
  logic                        s_fire, m_fire;
  pfe_pkg::pfe_result_t        par_res;

  logic                        out_valid;
  pfe_pkg::status_t            out_status;
  logic [pfe_pkg::VALUE_W-1:0] out_value;
  logic                        skid_valid;
  pfe_pkg::status_t            skid_status;
  logic [pfe_pkg::VALUE_W-1:0] skid_value;

  logic                        stalled_result;
  logic                        dataless_out;

  assign s_axis_tready = !skid_valid;
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign m_fire        = m_axis_tvalid && m_axis_tready;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_value;
  assign m_axis_tuser  = out_status;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      target_field <= pfe_pkg::FIELD_W'(1);
      search_mode  <= pfe_pkg::MODE_VARINT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pfe_pkg::CFG_TARGET_FIELD: target_field <= cfg_data[pfe_pkg::FIELD_W-1:0];
        pfe_pkg::CFG_SEARCH_MODE:  search_mode  <= cfg_data[0];
        default:                   search_mode  <= search_mode;
      endcase
    end
  end

  pfe_parser u_parser (
    .clk            (clk),
    .rst            (rst),
    .accept         (s_fire),
    .data_byte      (s_axis_tdata),
    .end_of_message (s_axis_tlast),
    .target_field   (target_field),
    .search_mode    (search_mode),
    .result         (par_res)
  );

  // Output register with a skid entry behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (m_fire || !out_valid) begin
        if (skid_valid) begin
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          out_valid <= s_fire && par_res.have;
        end
      end else if (s_fire && par_res.have) begin
        skid_valid <= 1'b1;
      end
    end
  end

  // Payload of the output register and skid entry.
  always_ff @(posedge clk) begin
    if (m_fire || !out_valid) begin
      if (skid_valid) begin
        out_status <= skid_status;
        out_value  <= skid_value;
      end else begin
        out_status <= par_res.status;
        out_value  <= par_res.value;
      end
    end else if (s_fire && par_res.have) begin
      skid_status <= par_res.status;
      skid_value  <= par_res.value;
    end
  end

  // Conditions watched by the assertions below.
  assign stalled_result = s_fire && par_res.have && m_axis_tvalid && !m_axis_tready;
  assign dataless_out   = m_axis_tvalid && ((m_axis_tuser == pfe_pkg::ST_EMPTY) ||
                          (m_axis_tuser == pfe_pkg::ST_NOTFOUND) ||
                          (m_axis_tuser == pfe_pkg::ST_MALFORMED));

  // A waiting skid entry always has a full output register ahead of it.
  `PFE_ASSERT_NOW(a_skid_behind_out, clk, rst, skid_valid, out_valid, "skid full, output empty")

  // A result arriving while the output is stalled must land in the skid entry.
  `PFE_ASSERT_NEXT(a_stall_to_skid, clk, rst, stalled_result, skid_valid, "stalled result lost")

  // Statuses without data carry a zero value.
  `PFE_ASSERT_NOW(a_zero_value, clk, rst, dataless_out, m_axis_tdata == '0, "value on dataless status")

endmodule
